### sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
`default_nettype none

package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STAT_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_OFFER     = 3'd0,
    KIND_POLL      = 3'd1,
    KIND_PEEK      = 3'd2,
    KIND_READ_AT   = 3'd3,
    KIND_REMOVE_MT = 3'd4,
    KIND_REMOVE_AT = 3'd5
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;  // insert new entry in order, shift tail right
    logic             del;  // close gap, shift tail left
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_cmd_t;

endpackage

`default_nettype wire

### sv/spq_cell.sv
// One slot of the sorted entry row: holds a key and tag, moves them to or from neighbors.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic                    clk_i,
  input  wire spq_pkg::cell_cmd_t      cmd_i,
  input  wire logic                    valid_i,
  input  wire logic                    kill_i,
  input  wire logic                    ins_in_i,
  output logic                         ins_out_o,
  input  wire logic                    del_in_i,
  output logic                         del_out_o,
  input  wire logic [spq_pkg::KEY_W-1:0] left_key_i,
  input  wire logic [spq_pkg::TAG_W-1:0] left_tag_i,
  input  wire logic [spq_pkg::KEY_W-1:0] right_key_i,
  input  wire logic [spq_pkg::TAG_W-1:0] right_tag_i,
  output logic [spq_pkg::KEY_W-1:0]    key_o,
  output logic [spq_pkg::TAG_W-1:0]    tag_o,
  output logic                         take_new_o,
  output logic                         match_o
);

  logic [spq_pkg::KEY_W-1:0] key_q, key_d;
  logic [spq_pkg::TAG_W-1:0] tag_q, tag_d;
  logic                      lt;

  // Entry stays ahead of a new one only if its key is strictly smaller.
  assign lt         = valid_i && (key_q < cmd_i.key);
  assign ins_out_o  = ins_in_i | ~lt;
  assign take_new_o = ~lt & ~ins_in_i;
  assign del_out_o  = del_in_i | kill_i;
  assign match_o    = valid_i && (tag_q == cmd_i.tag);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (cmd_i.ins) begin
      if (ins_in_i) begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end else if (!lt) begin
        key_d = cmd_i.key;
        tag_d = cmd_i.tag;
      end
    end else if (cmd_i.del && del_out_o) begin
      key_d = right_key_i;
      tag_d = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

### sv/sorted_priority_queue.sv
// Operations: offer, poll, peek, read_at, remove_at register their result in the cycle after the
//   input transfer; one such operation per cycle while the result side keeps taking.
// Remove_matching runs as a compaction pass: the cell row closes one matching
//   slot per cycle, then the count is reported.
// Reset: asynchronous, active low; clears occupancy, sequencer and output valid. Entry
//   storage keeps whatever it held and is only read below the occupancy count.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [spq_pkg::KIND_W-1:0] kind_i,
  input  wire logic [spq_pkg::KEY_W-1:0]  key_i,
  input  wire logic [spq_pkg::TAG_W-1:0]  tag_i,
  input  wire logic [spq_pkg::POS_W-1:0]  position_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [spq_pkg::STAT_W-1:0]      status_o,
  output logic [spq_pkg::KEY_W-1:0]       out_key_o,
  output logic [spq_pkg::TAG_W-1:0]       out_tag_o,
  output logic [spq_pkg::CNT_W-1:0]       out_count_o,
  output logic [spq_pkg::CNT_W-1:0]       occupancy_o
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  // Sequencer: idle takes operations; match runs the remove-matching compaction.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MATCH = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [spq_pkg::CNT_W-1:0] count_q, count_d;
  logic [spq_pkg::CNT_W-1:0] removed_q, removed_d;
  logic [spq_pkg::TAG_W-1:0] mtag_q, mtag_d;

  // Output register, parts the result side from the input side.
  logic                      out_valid_q, out_valid_d;
  logic [spq_pkg::STAT_W-1:0] status_q, status_d;
  logic [spq_pkg::KEY_W-1:0] okey_q, okey_d;
  logic [spq_pkg::TAG_W-1:0] otag_q, otag_d;
  logic [spq_pkg::CNT_W-1:0] ocount_q, ocount_d;
  logic [spq_pkg::CNT_W-1:0] occ_q, occ_d;
  logic                      load_out;

  logic in_xfer, out_xfer;

  // Cell row signals.
  spq_pkg::cell_cmd_t        cmd;
  logic [N-1:0]              valid, kill, take_new, match;
  logic [N:0]                ins_chain, del_chain;
  logic [spq_pkg::KEY_W-1:0] cell_key [N];
  logic [spq_pkg::TAG_W-1:0] cell_tag [N];

  logic                      del_sel;    // delete the slot addressed by sel_pos
  logic                      match_mode; // delete the first matching slot
  logic [spq_pkg::IDX_W-1:0] sel_pos;
  logic [spq_pkg::IDX_W-1:0] ins_pos;
  logic                      full, empty, pos_ok, any_match;
  logic [spq_pkg::IDX_W-1:0] rd_idx;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;

  assign full      = (count_q == spq_pkg::CNT_W'(N));
  assign empty     = (count_q == '0);
  assign pos_ok    = ({1'b0, position_i} < count_q);
  assign any_match = |match;
  assign rd_idx    = position_i[spq_pkg::IDX_W-1:0];

  // Occupancy mask and the deletion origin for each slot.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid[i] = (spq_pkg::CNT_W'(i) < count_q);
      kill[i]  = match_mode ? match[i] : (del_sel && (sel_pos == spq_pkg::IDX_W'(i)));
    end
  end

  // Encode the one-hot insert slot.
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < N; i++) begin
      if (take_new[i]) ins_pos = ins_pos | spq_pkg::IDX_W'(i);
    end
  end

  assign ins_chain[0] = 1'b0;
  assign del_chain[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [spq_pkg::KEY_W-1:0] lkey, rkey;
    logic [spq_pkg::TAG_W-1:0] ltag, rtag;

    if (g == 0) begin : g_head
      assign lkey = '0;
      assign ltag = '0;
    end else begin : g_mid
      assign lkey = cell_key[g-1];
      assign ltag = cell_tag[g-1];
    end

    if (g == N - 1) begin : g_tail
      assign rkey = '0;
      assign rtag = '0;
    end else begin : g_body
      assign rkey = cell_key[g+1];
      assign rtag = cell_tag[g+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (valid[g]),
      .kill_i      (kill[g]),
      .ins_in_i    (ins_chain[g]),
      .ins_out_o   (ins_chain[g+1]),
      .del_in_i    (del_chain[g]),
      .del_out_o   (del_chain[g+1]),
      .left_key_i  (lkey),
      .left_tag_i  (ltag),
      .right_key_i (rkey),
      .right_tag_i (rtag),
      .key_o       (cell_key[g]),
      .tag_o       (cell_tag[g]),
      .take_new_o  (take_new[g]),
      .match_o     (match[g])
    );
  end

  // Operation decode and sequencing.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    removed_d  = removed_q;
    mtag_d     = mtag_q;
    cmd.ins    = 1'b0;
    cmd.del    = 1'b0;
    cmd.key    = key_i;
    cmd.tag    = (state_q == ST_MATCH) ? mtag_q : tag_i;
    del_sel    = 1'b0;
    match_mode = 1'b0;
    sel_pos    = '0;
    load_out   = 1'b0;
    status_d   = spq_pkg::STAT_OK;
    okey_d     = '0;
    otag_d     = '0;
    ocount_d   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (spq_pkg::kind_e'(kind_i))
            spq_pkg::KIND_OFFER: begin
              load_out = 1'b1;
              if (full) begin
                status_d = spq_pkg::STAT_FULL;
              end else begin
                cmd.ins  = 1'b1;
                count_d  = count_q + 1'b1;
                ocount_d = spq_pkg::CNT_W'(ins_pos);
              end
            end
            spq_pkg::KIND_POLL, spq_pkg::KIND_PEEK: begin
              load_out = 1'b1;
              if (empty) begin
                status_d = spq_pkg::STAT_EMPTY;
              end else begin
                okey_d = cell_key[0];
                otag_d = cell_tag[0];
                if (spq_pkg::kind_e'(kind_i) == spq_pkg::KIND_POLL) begin
                  cmd.del = 1'b1;
                  del_sel = 1'b1;
                  count_d = count_q - 1'b1;
                end
              end
            end
            spq_pkg::KIND_READ_AT, spq_pkg::KIND_REMOVE_AT: begin
              load_out = 1'b1;
              if (!pos_ok) begin
                status_d = spq_pkg::STAT_EMPTY;
              end else begin
                okey_d = cell_key[rd_idx];
                otag_d = cell_tag[rd_idx];
                if (spq_pkg::kind_e'(kind_i) == spq_pkg::KIND_REMOVE_AT) begin
                  cmd.del = 1'b1;
                  del_sel = 1'b1;
                  sel_pos = rd_idx;
                  count_d = count_q - 1'b1;
                end
              end
            end
            spq_pkg::KIND_REMOVE_MT: begin
              // Hold the tag and start the compaction pass.
              mtag_d    = tag_i;
              removed_d = '0;
              state_d   = ST_MATCH;
            end
            default: begin
              load_out = 1'b1;
              status_d = spq_pkg::STAT_EMPTY;
            end
          endcase
        end
      end
      ST_MATCH: begin
        match_mode = 1'b1;
        if (any_match) begin
          // Drop the first matching slot; everything behind it advances.
          cmd.del   = 1'b1;
          count_d   = count_q - 1'b1;
          removed_d = removed_q + 1'b1;
        end else begin
          load_out = 1'b1;
          ocount_d = removed_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    occ_d = count_d;

    out_valid_d = out_valid_q;
    if (out_xfer) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    mtag_q    <= mtag_d;
    if (load_out) begin
      status_q <= status_d;
      okey_q   <= okey_d;
      otag_q   <= otag_d;
      ocount_q <= ocount_d;
      occ_q    <= occ_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_key_o   = okey_q;
  assign out_tag_o   = otag_q;
  assign out_count_o = ocount_q;
  assign occupancy_o = occ_q;

endmodule

`default_nettype wire
